// File: rtl/core/scgr_pkg.sv
// Package for the scaled glyph rectangle generator.
// Holds the glyph ROM, the controller state type and the control structs.
// No dependencies.
package scgr_pkg;

  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_ROWS = 7;
  localparam int GLYPH_PIX  = GLYPH_COLS * GLYPH_ROWS;

  // Pixel k of a glyph is column k / 7, row k % 7.
  typedef logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] glyph_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_WALK = 3'b100
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // an input item is taken this cycle
    logic lookup;   // glyph lookup and cursor update
    logic advance;  // move the walker to the next pixel
  } scgr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic blank;     // looked-up glyph has no pixel set
    logic pix_now;   // pixel under the walker is set
    logic last_pix;  // no set pixel after the current one
    logic out_free;  // output register can take a rectangle
  } scgr_sts_t;

  // Builds a glyph from its five column bytes, column 0 first.
  function automatic glyph_t mk_glyph(input logic [7:0] c0, input logic [7:0] c1,
                                      input logic [7:0] c2, input logic [7:0] c3,
                                      input logic [7:0] c4);
    glyph_t g;
    g = {c4[6:0], c3[6:0], c2[6:0], c1[6:0], c0[6:0]};
    return g;
  endfunction

  // Fixed font ROM; every code outside it draws the blank glyph.
  function automatic glyph_t glyph_lookup(input logic [7:0] code);
    glyph_t g;
    unique case (code)
      8'h25:   g = mk_glyph(8'h23, 8'h13, 8'h08, 8'h64, 8'h62);
      8'h2D:   g = mk_glyph(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
      8'h2E:   g = mk_glyph(8'h00, 8'h60, 8'h60, 8'h00, 8'h00);
      8'h2F:   g = mk_glyph(8'h20, 8'h10, 8'h08, 8'h04, 8'h02);
      8'h30:   g = mk_glyph(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
      8'h31:   g = mk_glyph(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
      8'h32:   g = mk_glyph(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
      8'h33:   g = mk_glyph(8'h21, 8'h41, 8'h45, 8'h4B, 8'h31);
      8'h34:   g = mk_glyph(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
      8'h35:   g = mk_glyph(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
      8'h36:   g = mk_glyph(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30);
      8'h37:   g = mk_glyph(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
      8'h38:   g = mk_glyph(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
      8'h39:   g = mk_glyph(8'h06, 8'h49, 8'h49, 8'h29, 8'h1E);
      8'h3A:   g = mk_glyph(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);
      8'h41:   g = mk_glyph(8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E);
      8'h43:   g = mk_glyph(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
      8'h45:   g = mk_glyph(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
      8'h48:   g = mk_glyph(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
      8'h49:   g = mk_glyph(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
      8'h4D:   g = mk_glyph(8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F);
      8'h50:   g = mk_glyph(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
      8'h52:   g = mk_glyph(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
      8'h54:   g = mk_glyph(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
      8'h55:   g = mk_glyph(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

// File: rtl/core/scaled_glyph_rect_generator_top.sv
// Top level of the scaled glyph rectangle generator.
// Joins scgr_ctrl and scgr_datapath; depends on scgr_pkg.
//
//   channel | direction | tdata                                   | tuser / tlast
//   in_     | slave     | code, origin_x, origin_y, color, scale  | tuser: first_of_string
//   out_    | master    | rect_x, rect_y, rect_side, rect_color   | tlast: last_rect
//
// An item is accepted, then looked up, and then walked pixel by pixel up to the last set
// pixel by the pixel walker over the 35 pixels of the 5x7 glyph, one pixel per cycle unless
// a set pixel waits for the output register. A blank glyph returns to idle after lookup.
// Reset clears the cursor to 0 and empties the output register.
// A stalled output holds the walker on a set pixel until the rectangle is taken;
// the next item is taken while the final rectangle still waits.
module scaled_glyph_rect_generator_top
  import scgr_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] char_code, [23:8] origin_x, [39:24] origin_y, [47:40] color, [55:48] scale
  input  logic [55:0] in_tdata,
  // [0] first_of_string
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] rect_x, [31:16] rect_y, [39:32] rect_side, [47:40] rect_color
  output logic [47:0] out_tdata,
  output logic        out_tlast
);

  scgr_cmd_t   cmd;
  scgr_sts_t   sts;
  logic [15:0] rect_x, rect_y;
  logic [7:0]  rect_side, rect_color;

  scgr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  scgr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .char_code       (in_tdata[7:0]),
    .origin_x        (in_tdata[23:8]),
    .origin_y        (in_tdata[39:24]),
    .color           (in_tdata[47:40]),
    .scale           (in_tdata[55:48]),
    .first_of_string (in_tuser),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .rect_x          (rect_x),
    .rect_y          (rect_y),
    .rect_side       (rect_side),
    .rect_color      (rect_color),
    .last_rect       (out_tlast)
  );

  assign out_tdata = {rect_color, rect_side, rect_y, rect_x};

  // An accepted item always passes through lookup before the next one is taken.
  a_lookup_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken twice in a row");

  // A pending rectangle that is not the last of its glyph means the walk goes on.
  a_busy_while_glyph_open: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> !in_tready)
    else $error("input ready while a glyph is still being drawn");

  // Every rectangle has a nonzero side.
  a_side_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[39:32] != 8'd0))
    else $error("rectangle with zero side");

endmodule

// File: rtl/core/scgr_ctrl.sv
// Controller of the scaled glyph rectangle generator.
// One-hot state machine that sequences capture, lookup and the pixel walk.
// Depends on scgr_pkg.
module scgr_ctrl
  import scgr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  scgr_sts_t sts,
  output scgr_cmd_t cmd
);

  state_t state_r, state_nxt;

  // Items are taken only when the walker is free.
  assign in_tready   = (state_r == ST_IDLE);
  assign cmd.capture = in_tvalid && in_tready;
  assign cmd.lookup  = (state_r == ST_LOAD);
  // An unset pixel is skipped at once; a set one waits for the output register.
  assign cmd.advance = (state_r == ST_WALK) && (!sts.pix_now || sts.out_free);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.capture) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        state_nxt = sts.blank ? ST_IDLE : ST_WALK;
      end
      ST_WALK: begin
        if (cmd.advance && sts.last_pix) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/core/scgr_datapath.sv
// Datapath of the scaled glyph rectangle generator.
// Holds the captured item, the cursor, the pixel walker and the output register.
// Depends on scgr_pkg.
module scgr_datapath
  import scgr_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  scgr_cmd_t   cmd,
  output scgr_sts_t   sts,
  input  logic [7:0]  char_code,
  input  logic [15:0] origin_x,
  input  logic [15:0] origin_y,
  input  logic [7:0]  color,
  input  logic [7:0]  scale,
  input  logic        first_of_string,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] rect_x,
  output logic [15:0] rect_y,
  output logic [7:0]  rect_side,
  output logic [7:0]  rect_color,
  output logic        last_rect
);

  // Captured item.
  logic [7:0]            code_r;
  logic [COORD_BITS-1:0] ox_r, oy_r;
  logic [7:0]            color_r, side_r;
  logic                  first_r;

  // Walker and cursor.
  logic [GLYPH_PIX-1:0]  pix_r;
  logic [2:0]            row_r;
  logic [COORD_BITS-1:0] x_r, y_r, cursor_r;
  logic [COORD_BITS-1:0] px, adv6;

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  logic [15:0]           rect_x_r, rect_y_r;
  logic [7:0]            rect_side_r, rect_color_r;
  logic                  last_rect_r;

  logic [COORD_BITS-1:0] ox_ext, oy_ext;
  logic                  emit;

  // Origins are sign-extended or cut to the coordinate width.
  assign ox_ext = COORD_BITS'(signed'(origin_x));
  assign oy_ext = COORD_BITS'(signed'(origin_y));

  assign px   = first_r ? ox_r : cursor_r;
  assign adv6 = COORD_BITS'({side_r, 2'b00}) + COORD_BITS'({side_r, 1'b0});
  assign emit = cmd.advance && pix_r[0];

  assign sts.blank    = (glyph_lookup(code_r) == '0);
  assign sts.pix_now  = pix_r[0];
  assign sts.last_pix = (pix_r[GLYPH_PIX-1:1] == '0);
  assign sts.out_free = !out_valid_r || out_ready;

  // Capture the item; a zero scale counts as one.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      code_r  <= char_code;
      ox_r    <= ox_ext;
      oy_r    <= oy_ext;
      color_r <= color;
      side_r  <= (scale == 8'd0) ? 8'd1 : scale;
      first_r <= first_of_string;
    end
  end

  // Cursor moves on by six columns after every character, blank ones too.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
    end else if (cmd.lookup) begin
      cursor_r <= px + adv6;
    end
  end

  // Pixel walker: rows inside a column, then the next column.
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      pix_r <= glyph_lookup(code_r);
      row_r <= 3'd0;
      x_r   <= px;
      y_r   <= oy_r;
    end else if (cmd.advance) begin
      pix_r <= pix_r >> 1;
      if (row_r == 3'(GLYPH_ROWS - 1)) begin
        row_r <= 3'd0;
        x_r   <= x_r + COORD_BITS'(side_r);
        y_r   <= oy_r;
      end else begin
        row_r <= row_r + 3'd1;
        y_r   <= y_r + COORD_BITS'(side_r);
      end
    end
  end

  // Output valid flag.
  always_comb begin
    if (emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload, loaded for each set pixel.
  always_ff @(posedge clk) begin
    if (emit) begin
      rect_x_r     <= 16'(x_r);
      rect_y_r     <= 16'(y_r);
      rect_side_r  <= side_r;
      rect_color_r <= color_r;
      last_rect_r  <= sts.last_pix;
    end
  end

  assign out_valid  = out_valid_r;
  assign rect_x     = rect_x_r;
  assign rect_y     = rect_y_r;
  assign rect_side  = rect_side_r;
  assign rect_color = rect_color_r;
  assign last_rect  = last_rect_r;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for scaled_glyph_rect_generator_top.
// Drives character items on the in_ stream and checks every rectangle on the out_ stream
// against a local glyph walker; needs only the RTL (scgr_pkg for the glyph dimensions).
`timescale 1ns / 1ps

module testbench;
  import scgr_pkg::GLYPH_COLS;
  import scgr_pkg::GLYPH_ROWS;

  localparam int FONT_SIZE    = 26;
  localparam int DRAIN_CYCLES = 48;
  localparam int STALL_CYCLES = 400;
  localparam int STALL_AT     = 40;
  localparam int WATCHDOG_MAX = 4000;

  typedef struct packed {
    logic [7:0]  code;
    logic [15:0] ox;
    logic [15:0] oy;
    logic [7:0]  color;
    logic [7:0]  scale;
    logic        first;
  } char_item_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  side;
    logic [7:0]  color;
    logic        last;
  } rect_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tlast;

  char_item_t  pending_chars[$];
  rect_t       expected_rects[$];
  logic [15:0] pen_x = '0;
  logic        in_taken = 1'b0;
  int          chars_accepted = 0;
  int          fail_count = 0;
  int          idle_cycles = 0;
  int          tx_idle_pct = 20;
  int          rx_idle_pct = 74;
  int          rx_stall_left = 0;
  logic        rx_stall_done = 1'b0;

  scaled_glyph_rect_generator_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  // Font table: code in the top byte, then column 0 down to column 4.
  function automatic logic [47:0] font_entry(input int idx);
    case (idx)
      0:       return 48'h20_00_00_00_00_00;
      1:       return 48'h25_23_13_08_64_62;
      2:       return 48'h2D_08_08_08_08_08;
      3:       return 48'h2E_00_60_60_00_00;
      4:       return 48'h2F_20_10_08_04_02;
      5:       return 48'h30_3E_51_49_45_3E;
      6:       return 48'h31_00_42_7F_40_00;
      7:       return 48'h32_42_61_51_49_46;
      8:       return 48'h33_21_41_45_4B_31;
      9:       return 48'h34_18_14_12_7F_10;
      10:      return 48'h35_27_45_45_45_39;
      11:      return 48'h36_3C_4A_49_49_30;
      12:      return 48'h37_01_71_09_05_03;
      13:      return 48'h38_36_49_49_49_36;
      14:      return 48'h39_06_49_49_29_1E;
      15:      return 48'h3A_00_36_36_00_00;
      16:      return 48'h41_7E_11_11_11_7E;
      17:      return 48'h43_3E_41_41_41_22;
      18:      return 48'h45_7F_49_49_49_41;
      19:      return 48'h48_7F_08_08_08_7F;
      20:      return 48'h49_00_41_7F_41_00;
      21:      return 48'h4D_7F_02_0C_02_7F;
      22:      return 48'h50_7F_09_09_09_06;
      23:      return 48'h52_7F_09_19_29_46;
      24:      return 48'h54_01_01_7F_01_01;
      25:      return 48'h55_3F_40_40_40_3F;
      default: return 48'h20_00_00_00_00_00;
    endcase
  endfunction

  // Walks the glyph column by column and queues one square per set pixel.
  // Unknown codes fall back to the blank entry; the pen advances either way.
  task automatic predict_char_rects(input char_item_t ch);
    logic [47:0] entry;
    logic [7:0]  side;
    logic [15:0] base_x;
    logic [7:0]  col_bits;
    rect_t       sq;
    int          n;
    entry = font_entry(0);
    n = 0;
    for (int i = 0; i < FONT_SIZE; i++) begin
      if (font_entry(i) >> 40 == 48'(ch.code)) begin
        entry = font_entry(i);
      end
    end
    side = (ch.scale == 8'd0) ? 8'd1 : ch.scale;
    base_x = ch.first ? ch.ox : pen_x;
    for (int col = 0; col < GLYPH_COLS; col++) begin
      col_bits = entry[39 - 8 * col -: 8];
      for (int row = 0; row < GLYPH_ROWS; row++) begin
        if (col_bits[row]) begin
          sq.x = base_x + 16'(col * side);
          sq.y = ch.oy + 16'(row * side);
          sq.side = side;
          sq.color = ch.color;
          sq.last = 1'b0;
          expected_rects.push_back(sq);
          n++;
        end
      end
    end
    if (n > 0) begin
      expected_rects[expected_rects.size() - 1].last = 1'b1;
    end
    pen_x = base_x + 16'((GLYPH_COLS + 1) * side);
  endtask

  task automatic queue_char(input logic [7:0] code, input logic [15:0] ox,
                            input logic [15:0] oy, input logic [7:0] color,
                            input logic [7:0] scale, input logic first);
    char_item_t ch;
    ch.code = code;
    ch.ox = ox;
    ch.oy = oy;
    ch.color = color;
    ch.scale = scale;
    ch.first = first;
    pending_chars.push_back(ch);
  endtask

  // Mostly well-formed strings of known glyphs at small scales, with some
  // unknown codes, wild scales and strings that lack a proper first flag.
  task automatic queue_random_strings(input int count);
    int          queued;
    int          len;
    int          roll;
    logic [7:0]  code;
    logic [7:0]  scale;
    logic        first;
    queued = 0;
    while (queued < count) begin
      len = $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          code = 8'($urandom_range(0, 255));
        end else begin
          code = 8'(font_entry($urandom_range(0, FONT_SIZE - 1)) >> 40);
        end
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
          scale = 8'd0;
        end else if (roll == 1) begin
          scale = 8'($urandom_range(0, 255));
        end else begin
          scale = 8'($urandom_range(1, 4));
        end
        first = (k == 0);
        if ($urandom_range(0, 9) == 0) begin
          first = 1'($urandom_range(0, 1));
        end
        queue_char(code, 16'($urandom), 16'($urandom), 8'($urandom_range(0, 255)),
                   scale, first);
        queued++;
      end
    end
  endtask

  // Holds the sender back until every queued item is in and every square is out.
  task automatic wait_for_drain();
    while (pending_chars.size() != 0 || in_tvalid || expected_rects.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Stimulus: directed corner cases, then three random phases with different idling.
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // No first character yet, so the reset pen position is used.
    queue_char(8'h41, 16'h1234, 16'h0000, 8'h00, 8'd1, 1'b0);
    queue_char(8'h38, 16'h0000, 16'h0010, 8'hFF, 8'd0, 1'b0);
    // Blank glyph and unknown codes emit nothing but move the pen.
    queue_char(8'h20, 16'h0000, 16'h0020, 8'h11, 8'd3, 1'b0);
    queue_char(8'h00, 16'h0000, 16'h0030, 8'h22, 8'd2, 1'b0);
    queue_char(8'hFF, 16'h7FFF, 16'h0040, 8'h33, 8'd255, 1'b1);
    // Coordinates wrap past the signed extremes.
    queue_char(8'h45, 16'h0000, 16'h7FFF, 8'hA5, 8'd255, 1'b0);
    queue_char(8'h48, 16'h8000, 16'h8000, 8'h5A, 8'd255, 1'b1);
    queue_char(8'h4D, 16'h0000, 16'hFFFF, 8'h0F, 8'd0, 1'b0);
    queue_char(8'h2E, 16'hFFFF, 16'h0000, 8'hF0, 8'd1, 1'b1);
    queue_char(8'h25, 16'h0000, 16'h0005, 8'h3C, 8'd2, 1'b0);
    queue_char(8'h31, 16'h0000, 16'd100, 8'hC3, 8'd128, 1'b1);
    queue_char(8'h7F, 16'hAAAA, 16'h5555, 8'h01, 8'd0, 1'b0);
    queue_char(8'h30, 16'h5555, 16'hAAAA, 8'h80, 8'd4, 1'b0);
    queue_char(8'h55, 16'h0001, 16'h7FFE, 8'h55, 8'hAA, 1'b1);
    queue_char(8'h54, 16'hFFFE, 16'h8001, 8'hAA, 8'h55, 1'b0);
    wait_for_drain();

    queue_random_strings(78);
    wait_for_drain();

    tx_idle_pct = 74;
    rx_idle_pct = 20;
    queue_random_strings(78);
    wait_for_drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random_strings(78);
    wait_for_drain();

    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Sender: a new item is offered only once the previous one has been taken.
  always @(negedge clk) begin
    char_item_t ch;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (pending_chars.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        ch = pending_chars.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {ch.scale, ch.color, ch.oy, ch.ox, ch.code};
        in_tuser <= ch.first;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off that fills the block.
  always @(negedge clk) begin
    if (rx_stall_left > 0) begin
      rx_stall_left <= rx_stall_left - 1;
      out_tready <= 1'b0;
    end else if (!rx_stall_done && chars_accepted >= STALL_AT) begin
      rx_stall_left <= STALL_CYCLES;
      rx_stall_done <= 1'b1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Monitor: predicts on each accepted item, checks each accepted square.
  always @(posedge clk) begin
    char_item_t ch;
    rect_t      got;
    rect_t      want;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      {ch.scale, ch.color, ch.oy, ch.ox, ch.code} = in_tdata;
      ch.first = in_tuser;
      predict_char_rects(ch);
      chars_accepted++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.x = out_tdata[15:0];
      got.y = out_tdata[31:16];
      got.side = out_tdata[39:32];
      got.color = out_tdata[47:40];
      got.last = out_tlast;
      if (expected_rects.size() == 0) begin
        $display("%0t: unexpected square x=%h y=%h side=%h color=%h last=%b", $time,
                 got.x, got.y, got.side, got.color, got.last);
        fail_count++;
      end else begin
        want = expected_rects.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.side !== want.side ||
            got.color !== want.color || got.last !== want.last) begin
          $display("%0t: square mismatch expected x=%h y=%h side=%h color=%h last=%b",
                   $time, want.x, want.y, want.side, want.color, want.last);
          $display("%0t:                 actual   x=%h y=%h side=%h color=%h last=%b",
                   $time, got.x, got.y, got.side, got.color, got.last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: ends the run if neither side moves an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX) begin
      $display("%0t: watchdog expired with %0d squares outstanding", $time,
               expected_rects.size());
      $display("testbench: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: scaled_glyph_rect_generator_top.f
rtl/core/scgr_pkg.sv
rtl/core/scgr_ctrl.sv
rtl/core/scgr_datapath.sv
rtl/core/scaled_glyph_rect_generator_top.sv
tb/testbench.sv
